// ===== rtl/rcpwd_pkg.sv =====
// shared types and constants for the dual rc pulse width decoder
`default_nettype none

package rcpwd_pkg;

   localparam int OFFSET_W = 10;
   localparam int SPAN_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int WIDTH_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd250;
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = 8'd250;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_SPAN   = 1'd1;

   // event kinds
   localparam logic FUNC_OVERFLOW = 1'b0;
   localparam logic FUNC_PIN      = 1'b1;

   typedef struct packed {
      logic               func;
      logic [COUNT_W-1:0] timer_count;
      logic               steering_level;
      logic               throttle_level;
   } req_type;

   typedef struct packed {
      logic               steering_valid;
      logic [COUNT_W-1:0] steering_width;
      logic               throttle_valid;
      logic [COUNT_W-1:0] throttle_width;
   } rsp_type;

   // per-channel control for one event step
   typedef struct packed {
      logic bump_ovf;
      logic sample;
      logic level;
   } chan_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/rcpwd_channel.sv =====
// one pulse measuring channel: state, width calculation and scaling
`default_nettype none

module rcpwd_channel
   import rcpwd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire chan_ctl_type        ctl,
   input  wire logic [COUNT_W-1:0]  timer_count,
   input  wire logic [OFFSET_W-1:0] pulse_offset,
   input  wire logic [SPAN_W-1:0]   pulse_span,
   output logic                     done,
   output logic [COUNT_W-1:0]       width
);

   logic               measuring_ff, measuring_in;
   logic [COUNT_W-1:0] start_ff, start_in;
   logic [COUNT_W-1:0] ovf_ff, ovf_in;
   logic               begin_pulse;
   logic [WIDTH_W-1:0] raw_w;
   logic [WIDTH_W-1:0] trim_w;

   assign begin_pulse = ctl.sample & ~measuring_ff & ctl.level;
   assign done        = ctl.sample & measuring_ff & ~ctl.level;

   always_comb begin
      measuring_in = measuring_ff;
      start_in     = start_ff;
      ovf_in       = ovf_ff;
      if (ctl.bump_ovf) begin
         ovf_in = ovf_ff + COUNT_W'(1);
      end
      if (begin_pulse) begin
         start_in     = timer_count;
         ovf_in       = '0;
         measuring_in = 1'b1;
      end
      if (done) begin
         measuring_in = 1'b0;
      end
   end

   // overflows * 256 + now - start, wrapping at 16 bits
   always_comb begin
      raw_w  = {ovf_ff, timer_count} - {{(WIDTH_W-COUNT_W){1'b0}}, start_ff};
      trim_w = '0;
      width  = '0;
      if (raw_w >= WIDTH_W'(pulse_offset)) begin
         trim_w = raw_w - WIDTH_W'(pulse_offset);
      end
      if (done) begin
         if (trim_w > WIDTH_W'(pulse_span)) begin
            width = pulse_span;
         end else begin
            width = trim_w[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff <= 1'b0;
         start_ff     <= '0;
         ovf_ff       <= '0;
      end else begin
         measuring_ff <= measuring_in;
         start_ff     <= start_in;
         ovf_ff       <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dual_rc_pulse_width_decoder.sv =====
// top level of the dual rc pulse width decoder: registers, handshake and channels
`default_nettype none

// measures the high time of the steering and throttle servo pulses. each
// req word is either a timer overflow (func 0) or a pin change sample
// (func 1) with the 8-bit timer value and both pin levels. every req word
// gives exactly one rsp word; a channel whose pulse ended with this word
// shows valid and its width (ticks less pulse_offset, floored at zero and
// clipped at pulse_span), otherwise valid and width are zero. a word is
// registered on entry and worked on between the input register and the
// rsp register; one word is taken every cycle while rsp_ready stays high.
// a stalled rsp holds the input register; req_ready follows rsp_ready
// through the pipeline enable. the user writes registers through csr_
// only while no word is in flight; the block itself does not enforce it.

module dual_rc_pulse_width_decoder
   import rcpwd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   // register write port
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [OFFSET_W-1:0] offset_ff;
   logic [SPAN_W-1:0]   span_ff;

   // input stage
   logic    in_valid_ff;
   req_type in_data_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic         advance;
   chan_ctl_type steer_ctl, throt_ctl;
   logic         steer_done, throt_done;
   logic [COUNT_W-1:0] steer_width, throt_width;

   // the input word moves on when the rsp register is free or being emptied
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         span_ff   <= SPAN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PULSE_OFFSET: begin
               offset_ff <= csr_data[OFFSET_W-1:0];
            end
            CSR_PULSE_SPAN: begin
               span_ff <= csr_data[SPAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // per-channel controls, only live when the word advances
   always_comb begin
      steer_ctl.bump_ovf = advance & (in_data_ff.func == FUNC_OVERFLOW);
      steer_ctl.sample   = advance & (in_data_ff.func == FUNC_PIN);
      steer_ctl.level    = in_data_ff.steering_level;
      throt_ctl.bump_ovf = advance & (in_data_ff.func == FUNC_OVERFLOW);
      throt_ctl.sample   = advance & (in_data_ff.func == FUNC_PIN);
      throt_ctl.level    = in_data_ff.throttle_level;
   end

   rcpwd_channel u_steering (
      .clock        (clock),
      .reset        (reset),
      .ctl          (steer_ctl),
      .timer_count  (in_data_ff.timer_count),
      .pulse_offset (offset_ff),
      .pulse_span   (span_ff),
      .done         (steer_done),
      .width        (steer_width)
   );

   rcpwd_channel u_throttle (
      .clock        (clock),
      .reset        (reset),
      .ctl          (throt_ctl),
      .timer_count  (in_data_ff.timer_count),
      .pulse_offset (offset_ff),
      .pulse_span   (span_ff),
      .done         (throt_done),
      .width        (throt_width)
   );

   // rsp register: load on advance, clear valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.steering_valid = steer_done;
         rsp_data_in.steering_width = steer_width;
         rsp_data_in.throttle_valid = throt_done;
         rsp_data_in.throttle_width = throt_width;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/dual_rc_pulse_width_decoder_tb.sv =====
// testbench for the dual rc pulse width decoder: directed and random event streams
`timescale 1ns / 1ps

module dual_rc_pulse_width_decoder_tb;
   import rcpwd_pkg::*;

   // clock, reset and the block's inputs, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the registers and of both channels (0 steering, 1 throttle)
   logic [OFFSET_W-1:0] offset_reg = OFFSET_RESET;
   logic [SPAN_W-1:0]   span_reg   = SPAN_RESET;
   logic                chan_busy [2] = '{1'b0, 1'b0};
   logic [COUNT_W-1:0]  chan_t0   [2] = '{8'd0, 8'd0};
   logic [COUNT_W-1:0]  chan_ovf  [2] = '{8'd0, 8'd0};

   // expected rsp words, oldest first
   rsp_type pending_results [$];
   int      errors = 0;

   // pacing of both sides
   logic gaps_on   = 1'b1;
   logic stalls_on = 1'b1;
   int   stall_left = 0;

   // pin levels as last driven by the random traffic
   logic pin_steer = 1'b0;
   logic pin_throt = 1'b0;

   dual_rc_pulse_width_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // ticks of a finished pulse after offset removal and clipping at the span
   function automatic logic [COUNT_W-1:0] pulse_ticks(input logic [COUNT_W-1:0] ovf,
                                                      input logic [COUNT_W-1:0] t0,
                                                      input logic [COUNT_W-1:0] now);
      logic [WIDTH_W-1:0] ticks;
      ticks = {ovf, 8'h00} + WIDTH_W'(now) - WIDTH_W'(t0);   // wraps mod 65536
      if (ticks < WIDTH_W'(offset_reg))
         ticks = WIDTH_W'(offset_reg);                       // short pulse floors at zero
      ticks = ticks - WIDTH_W'(offset_reg);
      if (ticks > WIDTH_W'(span_reg))
         ticks = WIDTH_W'(span_reg);
      return ticks[COUNT_W-1:0];
   endfunction

   // advances both channels by one event word and gives the rsp word it causes
   function automatic rsp_type decode_event(input req_type ev);
      rsp_type            res;
      logic               done  [2];
      logic [COUNT_W-1:0] ticks [2];
      logic               lvl;
      int                 ch;
      res = '0;
      for (ch = 0; ch < 2; ch++) begin
         done[ch]  = 1'b0;
         ticks[ch] = '0;
      end
      if (ev.func == FUNC_OVERFLOW) begin
         // timer count and levels play no part here
         for (ch = 0; ch < 2; ch++)
            chan_ovf[ch] = chan_ovf[ch] + 8'd1;
      end else begin
         for (ch = 0; ch < 2; ch++) begin
            lvl = (ch == 0) ? ev.steering_level : ev.throttle_level;
            if (!chan_busy[ch]) begin
               if (lvl) begin
                  // rising level while idle starts a measurement
                  chan_t0[ch]   = ev.timer_count;
                  chan_ovf[ch]  = '0;
                  chan_busy[ch] = 1'b1;
               end
            end else if (!lvl) begin
               // falling level while measuring ends the pulse
               ticks[ch]     = pulse_ticks(chan_ovf[ch], chan_t0[ch], ev.timer_count);
               done[ch]      = 1'b1;
               chan_busy[ch] = 1'b0;
            end
         end
      end
      res.steering_valid = done[0];
      res.steering_width = ticks[0];
      res.throttle_valid = done[1];
      res.throttle_width = ticks[1];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // scoreboard: expectation taken on each accepted req word, rsp checked
   // against the oldest one; one process so the order within an edge is fixed
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_results.push_back(decode_event(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: rsp word with none expected, expected nothing, actual %h",
                        $time, rsp_data);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("steering_valid", want.steering_valid, rsp_data.steering_valid);
               check_field("steering_width", want.steering_width, rsp_data.steering_width);
               check_field("throttle_valid", want.throttle_valid, rsp_data.throttle_valid);
               check_field("throttle_width", want.throttle_width, rsp_data.throttle_width);
            end
         end
      end
   end

   // rsp side back-pressure: random stalls while enabled
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (stalls_on && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 18);
      rsp_ready <= (stall_left == 0);
   end

   // ---------------------------------------------------------------------
   // shared stimulus tasks
   // ---------------------------------------------------------------------

   function automatic req_type pin_word(input logic [COUNT_W-1:0] cnt, input logic s,
                                        input logic t);
      req_type ev;
      ev.func           = FUNC_PIN;
      ev.timer_count    = cnt;
      ev.steering_level = s;
      ev.throttle_level = t;
      return ev;
   endfunction

   // overflow word with junk in the fields the block must ignore
   function automatic req_type overflow_word();
      req_type ev;
      ev.func           = FUNC_OVERFLOW;
      ev.timer_count    = COUNT_W'($urandom_range(0, 255));
      ev.steering_level = 1'($urandom_range(0, 1));
      ev.throttle_level = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   // offers one word and returns once it has been taken; valid stays high
   // so that a following word can go out back to back
   task automatic send_word(input req_type ev);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 17)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
   endtask

   // stops the sender and waits until every expected rsp word is in
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // margin after the last expected rsp word
   endtask

   // registers only change with nothing in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_PULSE_OFFSET)
         offset_reg = val[OFFSET_W-1:0];
      else if (idx == CSR_PULSE_SPAN)
         span_reg = val[SPAN_W-1:0];
   endtask

   // span write with the unused upper data bits filled at random
   task automatic write_span(input logic [SPAN_W-1:0] span);
      logic [CSR_DATA_W-SPAN_W-1:0] junk;
      junk = (CSR_DATA_W-SPAN_W)'($urandom_range(0, 3));
      write_reg(CSR_PULSE_SPAN, {junk, span});
   endtask

   // mostly well-formed pulse trains with random timer values, some overflow
   // words in between and a little noise with arbitrary levels
   task automatic run_traffic(input int count, input int ovf_pct);
      req_type ev;
      int      roll;
      int      i;
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < ovf_pct) begin
            ev = overflow_word();
         end else if (roll >= 95) begin
            pin_steer = 1'($urandom_range(0, 1));
            pin_throt = 1'($urandom_range(0, 1));
            ev = pin_word(COUNT_W'($urandom_range(0, 255)), pin_steer, pin_throt);
         end else begin
            case ($urandom_range(0, 2))
               0: pin_steer = ~pin_steer;
               1: pin_throt = ~pin_throt;
               default: begin
                  pin_steer = ~pin_steer;
                  pin_throt = ~pin_throt;
               end
            endcase
            ev = pin_word(COUNT_W'($urandom_range(0, 255)), pin_steer, pin_throt);
         end
         // sender holds off halfway until the pipeline is empty, unless running flat out
         if (gaps_on && i == count / 2)
            drain();
         send_word(ev);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // hand-picked words at reset settings (offset 250, span 250)
   task automatic test_directed();
      send_word(overflow_word());                 // overflow ignores the other fields
      send_word(pin_word(8'h00, 1'b0, 1'b0));     // low while idle, nothing happens
      send_word(pin_word(8'hFF, 1'b1, 1'b0));     // steering starts at top count
      send_word(overflow_word());
      send_word(overflow_word());
      send_word(pin_word(8'h10, 1'b1, 1'b0));     // high while measuring, nothing happens
      send_word(pin_word(8'h00, 1'b0, 1'b1));     // steering ends, throttle starts
      send_word(pin_word(8'h80, 1'b0, 1'b0));     // throttle shorter than offset gives zero
      send_word(pin_word(8'h20, 1'b1, 1'b1));     // both start together
      repeat (4) send_word(overflow_word());
      send_word(pin_word(8'h20, 1'b0, 1'b0));     // both end, clipped at span
      send_word(pin_word(8'h80, 1'b1, 1'b0));
      send_word(pin_word(8'h7F, 1'b0, 1'b0));     // count below start, 16-bit wrap
      send_word(pin_word(8'h00, 1'b1, 1'b1));
      send_word(pin_word(8'hFA, 1'b0, 1'b1));     // width equal to offset gives zero
      send_word(overflow_word());
      send_word(pin_word(8'hF5, 1'b1, 1'b0));     // throttle one above span, steering restarts
      send_word(overflow_word());
      send_word(pin_word(8'hF0, 1'b0, 1'b0));     // one tick above offset
      send_word(pin_word(8'hFF, 1'b0, 1'b0));
   endtask

   // a pulse spanning 256 overflows so the overflow counter wraps to zero
   task automatic test_counter_wrap();
      write_reg(CSR_PULSE_OFFSET, 10'd0);
      write_span(8'd255);
      send_word(pin_word(8'h40, 1'b1, 1'b1));
      repeat (256) send_word(overflow_word());
      send_word(pin_word(8'h50, 1'b0, 1'b1));     // steering sees only the 16 ticks
      send_word(pin_word(8'h3F, 1'b0, 1'b0));     // throttle wraps to the full 16-bit width
   endtask

   // several register settings, extremes first, each with its own traffic
   task automatic test_config_sweep();
      logic [OFFSET_W-1:0] off;
      logic [SPAN_W-1:0]   span;
      int                  pct;
      int                  k;
      for (k = 0; k < 6; k++) begin
         case (k)
            0: begin off = 10'd0;    span = 8'd0;   pct = 35; end
            1: begin off = 10'd1023; span = 8'd255; pct = 70; end
            2: begin off = 10'd0;    span = 8'd255; pct = 20; end
            3: begin off = 10'd1023; span = 8'd0;   pct = 70; end
            default: begin
               off  = OFFSET_W'($urandom_range(0, 700));
               span = SPAN_W'($urandom_range(0, 255));
               pct  = 50;
            end
         endcase
         write_reg(CSR_PULSE_OFFSET, off);
         write_span(span);
         run_traffic(180, pct);
      end
   endtask

   // closing stretch at reset settings with no gaps and no stalls
   task automatic test_back_to_back();
      write_reg(CSR_PULSE_OFFSET, CSR_DATA_W'(OFFSET_RESET));
      write_span(SPAN_RESET);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_traffic(380, 35);
   endtask

   initial begin
      // synchronous reset, released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_counter_wrap();
      test_config_sweep();
      test_back_to_back();

      drain();
      if (errors == 0)
         $display("dual_rc_pulse_width_decoder regression: pass");
      else
         $display("dual_rc_pulse_width_decoder regression: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("dual_rc_pulse_width_decoder regression: fail");
      $finish;
   end

endmodule
